### hdl/bdq_pkg.sv
`timescale 1ns / 1ps

package bdq_pkg;

  // Fixed field widths of the item and result, and the default capacity.
  localparam int DATA_W    = 32;
  localparam int ACT_W     = 2;
  localparam int ST_W      = 2;
  localparam int OCC_W     = 5;
  localparam int DEPTH_DEF = 16;

  // Operation requested by one item.
  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_REAR  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } action_e;

  // Outcome reported with each result.
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Per-cycle command broadcast from the controller to every cell.
  typedef struct packed {
    logic shift_right;  // push at the front: every word moves one cell back
    logic shift_left;   // pop at the front: every word moves one cell forward
    logic wr_rear;      // push at the rear: the cell at the fill level loads
    logic rd_en;        // a successful pop reads one cell
  } cell_cmd_t;

endpackage

### hdl/bdq_cell.sv
`timescale 1ns / 1ps

module bdq_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  logic                         clk_i,
  input  bdq_pkg::cell_cmd_t           cmd_i,
  input  logic [CNT_W-1:0]             count_i,
  input  logic [CNT_W-1:0]             rd_idx_i,
  input  logic [bdq_pkg::DATA_W-1:0]   push_value_i,
  input  logic [bdq_pkg::DATA_W-1:0]   prev_i,
  input  logic [bdq_pkg::DATA_W-1:0]   next_i,
  output logic [bdq_pkg::DATA_W-1:0]   data_o,
  output logic [bdq_pkg::DATA_W-1:0]   tap_o
);

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(INDEX);

  logic [bdq_pkg::DATA_W-1:0] data_q;
  logic [bdq_pkg::DATA_W-1:0] data_d;

  // Next word: take from the front neighbor, the back neighbor, or the pushed word.
  always_comb begin
    data_d = data_q;
    priority if (cmd_i.shift_right) begin
      data_d = prev_i;
    end else if (cmd_i.shift_left) begin
      data_d = next_i;
    end else if (cmd_i.wr_rear && (count_i == MyIdx)) begin
      data_d = push_value_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

  // The addressed cell drives its word onto the OR-combined read bus.
  assign tap_o = (cmd_i.rd_en && (rd_idx_i == MyIdx)) ? data_q : '0;

endmodule

### hdl/bdq_ctrl.sv
`timescale 1ns / 1ps

module bdq_ctrl #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [bdq_pkg::ACT_W-1:0]   action_i,
  output bdq_pkg::cell_cmd_t          cmd_o,
  output logic [CNT_W-1:0]            count_o,
  output logic [CNT_W-1:0]            rd_idx_o,
  output logic                        valid_o,
  output logic [bdq_pkg::ST_W-1:0]    status_o,
  output logic [bdq_pkg::OCC_W-1:0]   occupancy_o
);

  localparam logic [CNT_W-1:0] Full = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] One  = CNT_W'(1);

  logic [CNT_W-1:0]          count_q, count_d;
  logic                      valid_q;
  bdq_pkg::status_e          status_q, status_d;
  logic                      full, empty;

  assign full  = (count_q == Full);
  assign empty = (count_q == '0);

  // Decode the operation into a cell command and the new fill level.
  always_comb begin
    cmd_o    = '0;
    count_d  = count_q;
    status_d = bdq_pkg::ST_OK;
    rd_idx_o = '0;
    if (accept_i) begin
      unique case (bdq_pkg::action_e'(action_i))
        bdq_pkg::ACT_PUSH_FRONT: begin
          if (full) begin
            status_d = bdq_pkg::ST_FULL;
          end else begin
            cmd_o.shift_right = 1'b1;
            count_d = count_q + One;
          end
        end
        bdq_pkg::ACT_PUSH_REAR: begin
          if (full) begin
            status_d = bdq_pkg::ST_FULL;
          end else begin
            cmd_o.wr_rear = 1'b1;
            count_d = count_q + One;
          end
        end
        bdq_pkg::ACT_POP_FRONT: begin
          if (empty) begin
            status_d = bdq_pkg::ST_EMPTY;
          end else begin
            cmd_o.shift_left = 1'b1;
            cmd_o.rd_en = 1'b1;
            count_d = count_q - One;
          end
        end
        bdq_pkg::ACT_POP_REAR: begin
          if (empty) begin
            status_d = bdq_pkg::ST_EMPTY;
          end else begin
            cmd_o.rd_en = 1'b1;
            rd_idx_o = count_q - One;
            count_d = count_q - One;
          end
        end
        default: begin
          status_d = bdq_pkg::ST_OK;
        end
      endcase
    end
  end

  // Fill level and the registered status part of the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      valid_q  <= 1'b0;
      status_q <= bdq_pkg::ST_OK;
    end else begin
      count_q  <= count_d;
      valid_q  <= accept_i;
      if (accept_i) begin
        status_q <= status_d;
      end
    end
  end

  assign count_o     = count_q;
  assign valid_o     = valid_q;
  assign status_o    = status_q;
  assign occupancy_o = bdq_pkg::OCC_W'(count_q);

  // The fill level never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= Full)
    else $error("fill level above capacity");

  // A refused operation leaves the fill level where it was.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (status_d != bdq_pkg::ST_OK) |=> $stable(count_q))
    else $error("refused operation changed the fill level");

  // Every accepted item yields a result in the next cycle, and only then.
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_q == $past(accept_i))
    else $error("result strobe out of step with accepted items");

  // A full refusal is only reported when the queue was at capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (status_q == bdq_pkg::ST_FULL) |-> $past(full))
    else $error("full reported below capacity");

endmodule

### hdl/bounded_deque.sv
`timescale 1ns / 1ps

// Fixed-capacity double-ended queue of signed 32-bit words.
// Input channel: an item (action_i, push_value_i) is taken at a rising edge where
// start is high and busy is low. busy is held low: an item may be issued every cycle.
// action_i: 0 push at the front, 1 push at the rear, 2 pop from the front, 3 pop from
// the rear. push_value_i is ignored for pops.
// Result channel: exactly one result per item, shown for one cycle with valid_o high,
// in the cycle after the item was taken. pop_value_o holds the removed word on a good
// pop and zero otherwise; status_o is 0 ok, 1 push refused (full), 2 pop refused
// (empty); occupancy_o is the word count after the operation (low 5 bits).
// Throughput is one item per cycle: the words sit in a row of DEPTH cells that shift
// toward the back on a front push and toward the front on a front pop; a rear push
// loads the cell at the fill level and a rear pop reads the cell just below it.
// A refused operation leaves the contents unchanged.
// Reset empties the queue at once; no clearing pass is needed, as the fill level
// alone decides which cells hold words.
// The receiver cannot stall: a result not taken in its cycle is gone.

module bounded_deque #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic        [bdq_pkg::ACT_W-1:0]    action_i,
  input  logic signed [bdq_pkg::DATA_W-1:0]   push_value_i,
  output logic                                valid_o,
  output logic signed [bdq_pkg::DATA_W-1:0]   pop_value_o,
  output logic        [bdq_pkg::ST_W-1:0]     status_o,
  output logic        [bdq_pkg::OCC_W-1:0]    occupancy_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                        accept;
  bdq_pkg::cell_cmd_t          cmd;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            rd_idx;
  logic [bdq_pkg::DATA_W-1:0]  cell_data [DEPTH];
  logic [bdq_pkg::DATA_W-1:0]  cell_tap  [DEPTH];
  logic [bdq_pkg::DATA_W-1:0]  rd_word;
  logic [bdq_pkg::DATA_W-1:0]  pop_value_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  bdq_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .action_i    (action_i),
    .cmd_o       (cmd),
    .count_o     (count),
    .rd_idx_o    (rd_idx),
    .valid_o     (valid_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

  // Row of storage cells; cell 0 holds the front word.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [bdq_pkg::DATA_W-1:0] prev_word;
    logic [bdq_pkg::DATA_W-1:0] next_word;

    if (i == 0) begin : g_first
      assign prev_word = push_value_i;
    end else begin : g_mid_prev
      assign prev_word = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_word = '0;
    end else begin : g_mid_next
      assign next_word = cell_data[i+1];
    end

    bdq_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .count_i      (count),
      .rd_idx_i     (rd_idx),
      .push_value_i (push_value_i),
      .prev_i       (prev_word),
      .next_i       (next_word),
      .data_o       (cell_data[i]),
      .tap_o        (cell_tap[i])
    );
  end

  // At most one cell drives its tap, so an OR collects the popped word.
  always_comb begin
    rd_word = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_word = rd_word | cell_tap[k];
    end
  end

  // Popped word register; zero unless the pop succeeded.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pop_value_q <= cmd.rd_en ? rd_word : '0;
    end
  end

  assign pop_value_o = pop_value_q;

endmodule

### dv/bounded_deque_checker.sv
`timescale 1ns / 1ps

module bounded_deque_checker
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  logic        [ACT_W-1:0]  action_i,
  input  logic signed [DATA_W-1:0] push_value_i,
  input  logic                     valid_i,
  input  logic signed [DATA_W-1:0] pop_value_i,
  input  logic        [ST_W-1:0]   status_i,
  input  logic        [OCC_W-1:0]  occupancy_i,
  output int                       fail_count_o,
  output int                       pending_o,
  output int                       checked_o,
  output int                       full_hits_o,
  output int                       empty_hits_o
);

  // One predicted result, field by field.
  typedef struct {
    logic signed [DATA_W-1:0] pop_value;
    status_e                  status;
    logic        [OCC_W-1:0]  occupancy;
  } deque_result_t;

  // Shadow copy of the deque contents and pointers.
  logic signed [DATA_W-1:0] shadow_words [DEPTH];
  int unsigned              front_idx;
  int unsigned              word_count;

  // Results predicted for accepted items, oldest first.
  deque_result_t awaited_results [$];

  int fail_total;
  int checked_total;
  int full_total;
  int empty_total;

  // Applies one operation to the shadow deque and returns the result it produces.
  task automatic apply_deque_op(input action_e op, input logic signed [DATA_W-1:0] word,
                                output deque_result_t res);
    res.pop_value = '0;
    res.status    = ST_OK;
    case (op)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (word_count >= DEPTH) begin
          res.status = ST_FULL;
        end else if (op == ACT_PUSH_FRONT) begin
          front_idx = (front_idx + DEPTH - 1) % DEPTH;
          shadow_words[front_idx] = word;
          word_count++;
        end else begin
          shadow_words[(front_idx + word_count) % DEPTH] = word;
          word_count++;
        end
      end
      default: begin
        if (word_count == 0) begin
          res.status = ST_EMPTY;
        end else if (op == ACT_POP_FRONT) begin
          res.pop_value = shadow_words[front_idx];
          front_idx = (front_idx + 1) % DEPTH;
          word_count--;
        end else begin
          res.pop_value = shadow_words[(front_idx + word_count - 1) % DEPTH];
          word_count--;
        end
      end
    endcase
    res.occupancy = word_count[OCC_W-1:0];
  endtask

  // Compare each result with the oldest prediction, then predict for a newly taken item.
  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t want;
    deque_result_t fresh;
    if (!rst_ni) begin
      awaited_results.delete();
      front_idx     = 0;
      word_count    = 0;
      fail_total    = 0;
      checked_total = 0;
      full_total    = 0;
      empty_total   = 0;
      fail_count_o  <= 0;
      pending_o     <= 0;
      checked_o     <= 0;
      full_hits_o   <= 0;
      empty_hits_o  <= 0;
    end else begin
      if (valid_i) begin
        if (awaited_results.size() == 0) begin
          fail_total++;
          $display("%0t: result with nothing awaited: pop_value %0d status %0d occupancy %0d",
                   $time, pop_value_i, status_i, occupancy_i);
        end else begin
          want = awaited_results.pop_front();
          checked_total++;
          if (pop_value_i !== want.pop_value) begin
            fail_total++;
            $display("%0t: pop_value mismatch: expected %0d (0x%08h), actual %0d (0x%08h)",
                     $time, want.pop_value, want.pop_value, pop_value_i, pop_value_i);
          end
          if (status_i !== want.status) begin
            fail_total++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, status_i);
          end
          if (occupancy_i !== want.occupancy) begin
            fail_total++;
            $display("%0t: occupancy mismatch: expected %0d, actual %0d",
                     $time, want.occupancy, occupancy_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        apply_deque_op(action_e'(action_i), push_value_i, fresh);
        if (fresh.status == ST_FULL) full_total++;
        if (fresh.status == ST_EMPTY) empty_total++;
        awaited_results.push_back(fresh);
      end
      fail_count_o <= fail_total;
      pending_o    <= awaited_results.size();
      checked_o    <= checked_total;
      full_hits_o  <= full_total;
      empty_hits_o <= empty_total;
    end
  end

endmodule

### dv/bounded_deque_tb.sv
`timescale 1ns / 1ps

module bounded_deque_tb;
  import bdq_pkg::*;

  localparam int ITEM_TARGET = 1550;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     start        = 1'b0;
  logic                     busy;
  logic        [ACT_W-1:0]  action_i     = ACT_POP_FRONT;
  logic signed [DATA_W-1:0] push_value_i = '0;
  logic                     valid_o;
  logic signed [DATA_W-1:0] pop_value_o;
  logic        [ST_W-1:0]   status_o;
  logic        [OCC_W-1:0]  occupancy_o;

  int fail_count;
  int pending;
  int checked;
  int full_hits;
  int empty_hits;
  int items_sent = 0;
  bit idle_enable = 1'b1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bounded_deque #(
    .DEPTH(DEPTH_DEF)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .action_i    (action_i),
    .push_value_i(push_value_i),
    .valid_o     (valid_o),
    .pop_value_o (pop_value_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

  bounded_deque_checker #(
    .DEPTH(DEPTH_DEF)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .action_i    (action_i),
    .push_value_i(push_value_i),
    .valid_i     (valid_o),
    .pop_value_i (pop_value_o),
    .status_i    (status_o),
    .occupancy_i (occupancy_o),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .full_hits_o (full_hits),
    .empty_hits_o(empty_hits)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Words lean toward the extremes of the signed range now and then.
  function automatic logic [DATA_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 32'h8000_0000;
    if (r < 16) return 32'h7FFF_FFFF;
    if (r < 20) return 32'h0000_0000;
    if (r < 24) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Offers one item, holds it until taken, then idles for a random gap if idling is enabled.
  task automatic issue_op(input action_e op, input logic [DATA_W-1:0] word);
    int gap;
    start        <= 1'b1;
    action_i     <= op;
    push_value_i <= word;
    do @(posedge clk_i); while (busy);
    items_sent++;
    gap = idle_enable ? pick_gap() : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Holds off the sender until every outstanding result has come back.
  task automatic drain_pause();
    start <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  initial begin
    int          phase_len;
    int          push_pct;
    int          phase_count;
    action_e     op;
    logic [31:0] fill_words [4];

    fill_words  = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
    phase_count = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: pops on an empty queue, single-word pops from each end, filling to
    // capacity with wrap at the front, pushes while full, then a pop from each end.
    idle_enable = 1'b0;
    issue_op(ACT_POP_FRONT, $urandom);
    issue_op(ACT_POP_REAR, $urandom);
    issue_op(ACT_PUSH_FRONT, 32'h8000_0000);
    issue_op(ACT_POP_REAR, $urandom);
    issue_op(ACT_PUSH_REAR, 32'h7FFF_FFFF);
    issue_op(ACT_POP_FRONT, $urandom);
    for (int i = 0; i < DEPTH_DEF; i++) begin
      issue_op(i[0] ? ACT_PUSH_REAR : ACT_PUSH_FRONT, (i < 4) ? fill_words[i] : $urandom);
    end
    issue_op(ACT_PUSH_FRONT, $urandom);
    issue_op(ACT_PUSH_REAR, $urandom);
    issue_op(ACT_POP_FRONT, $urandom);
    issue_op(ACT_POP_REAR, $urandom);
    drain_pause();

    // Random phases that lean toward filling, draining or balance, so the
    // queue swings between full and empty and the pointers wrap often.
    while (items_sent < ITEM_TARGET) begin
      phase_len   = $urandom_range(10, 60);
      idle_enable = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 2))
        0:       push_pct = 80;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      for (int k = 0; k < phase_len; k++) begin
        if ($urandom_range(0, 99) < push_pct) begin
          op = $urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
        end else begin
          op = $urandom_range(0, 1) ? ACT_POP_REAR : ACT_POP_FRONT;
        end
        issue_op(op, pick_word());
      end
      phase_count++;
      if (phase_count % 8 == 0) begin
        drain_pause();
      end
    end

    // Let the last results come back and give any stray result time to show.
    drain_pause();
    repeat (3) @(posedge clk_i);

    $display("Run covered %0d items and %0d checked results in %0d random phases.",
             items_sent, checked, phase_count);
    $display("Pushes refused on a full queue: %0d, pops refused on an empty queue: %0d.",
             full_hits, empty_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("bounded_deque verification clean");
    end else begin
      $display("bounded_deque verification failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5_000_000;
    $display("Timed out with %0d results still awaited.", pending);
    $display("bounded_deque verification failed");
    $finish;
  end

endmodule

### bounded_deque.f
hdl/bdq_pkg.sv
hdl/bdq_cell.sv
hdl/bdq_ctrl.sv
hdl/bounded_deque.sv
dv/bounded_deque_checker.sv
dv/bounded_deque_tb.sv
